[src/ffa_pkg.sv]
`default_nettype none
package ffa_pkg;

    localparam int ADDR_W = 16;
    localparam int SIZE_W = 17;
    localparam int CNT_OUT_W = 9;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOFIT    = 2'd1,
        ST_NOTALLOC = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic                  op;
        logic [SIZE_W-1:0]     req_size;
        logic [ADDR_W-1:0]     block_addr;
        logic                  addr_valid;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]     granted_addr;
        status_t               status;
        logic [CNT_OUT_W-1:0]  free_entries;
        logic [CNT_OUT_W-1:0]  used_entries;
    } out_item_t;

    // One chunk of a list
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
    } seg_t;

    typedef enum logic [1:0] {
        WD_RDATA,
        WD_CAPT,
        WD_GRANT,
        WD_TAIL
    } wsel_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_INC,
        IDX_DEC,
        IDX_CNT,
        IDX_POS,
        IDX_POS1
    } idx_op_t;

    typedef struct packed {
        logic     load;
        logic     rd;
        logic     rd_prev;
        logic     wr;
        logic     wr_prev;
        logic     sel_used;
        wsel_t    wsel;
        idx_op_t  idx_op;
        logic     capture;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     set_status;
        status_t  status_val;
        logic     grant;
        logic     publish;
    } dp_cmd_t;

    typedef struct packed {
        logic is_free;
        logic addr_valid;
        logic req_zero;
        logic idx_zero;
        logic idx_end;
        logic hit;
        logic key_less;
        logic tail;
        logic free_full;
        logic used_full;
        logic out_busy;
    } dp_stat_t;

endpackage
`default_nettype wire

[src/first_fit_heap_allocator.sv]
// Each scan step is one RAM read; each step of the sorted insert or the shift-down
//   removal is one RAM read and one write.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: free list holds one chunk covering the whole heap, allocated list is empty;
//   no clearing pass, the result register is empty.
`default_nettype none
module first_fit_heap_allocator
    import ffa_pkg::*;
#(
    parameter int HEAP_BYTES = 65536,
    parameter int LIST_DEPTH = 256
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire in_item_t  req_item,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output out_item_t      rsp_item
);

    // Controller sequences scan, sorted insert and shift-down removal;
    // the datapath holds both lists in RAM plus the counters and the result.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    ffa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ffa_dp #(
        .HEAP_BYTES (HEAP_BYTES),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req_item  (req_item),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

    // A list step never reads and writes the RAM in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr && cmd.rd))
        else $error("read and write in one cycle");

    // Publish only into a free result slot
    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> !stat.out_busy)
        else $error("result overwritten");

    // A count never moves both ways at once
    a_cnt_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.cnt_inc, cmd.cnt_dec}))
        else $error("count inc and dec together");

    // Taking a request implies no result is being produced in that cycle
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !cmd.publish && !cmd.wr)
        else $error("load during work");

endmodule
`default_nettype wire

[src/ffa_ram.sv]
`default_nettype none
module ffa_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[src/ffa_ctrl.sv]
`default_nettype none
module ffa_ctrl
    import ffa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_SCAN_CHK,
        S_SCAN_CMP,
        S_INS_SET,
        S_INS_CHK,
        S_INS_CMP,
        S_POST,
        S_TAIL,
        S_REM_CHK,
        S_REM_MV,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (!stat.is_free && stat.req_zero)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = ST_NOFIT;
                    state_next     = S_FIN;
                end
                else if (stat.is_free && !stat.addr_valid)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                cmd.sel_used = stat.is_free;
                if (stat.idx_end)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = stat.is_free ? ST_NOTALLOC : ST_NOFIT;
                    state_next     = S_FIN;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                cmd.sel_used = stat.is_free;
                if (stat.hit)
                begin
                    if (stat.is_free ? stat.free_full : stat.used_full)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status_val = ST_FULL;
                        state_next     = S_FIN;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = S_INS_SET;
                    end
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_SCAN_CHK;
                end
            end
            S_INS_SET:
            begin
                cmd.sel_used = !stat.is_free;
                cmd.idx_op   = IDX_CNT;
                state_next   = S_INS_CHK;
            end
            S_INS_CHK:
            begin
                cmd.sel_used = !stat.is_free;
                if (stat.idx_zero)
                begin
                    cmd.wr      = 1'b1;
                    cmd.wsel    = stat.is_free ? WD_CAPT : WD_GRANT;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_POST;
                end
                else
                begin
                    cmd.rd      = 1'b1;
                    cmd.rd_prev = 1'b1;
                    state_next  = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                cmd.sel_used = !stat.is_free;
                cmd.wr       = 1'b1;
                if (stat.key_less)
                begin
                    cmd.wsel   = WD_RDATA;
                    cmd.idx_op = IDX_DEC;
                    state_next = S_INS_CHK;
                end
                else
                begin
                    cmd.wsel    = stat.is_free ? WD_CAPT : WD_GRANT;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_POST;
                end
            end
            S_POST:
            begin
                if (!stat.is_free && stat.tail)
                begin
                    cmd.idx_op = IDX_POS;
                    state_next = S_TAIL;
                end
                else
                begin
                    cmd.idx_op = IDX_POS1;
                    state_next = S_REM_CHK;
                end
            end
            S_TAIL:
            begin
                cmd.wr     = 1'b1;
                cmd.wsel   = WD_TAIL;
                cmd.grant  = 1'b1;
                state_next = S_FIN;
            end
            S_REM_CHK:
            begin
                cmd.sel_used = stat.is_free;
                if (stat.idx_end)
                begin
                    cmd.cnt_dec = 1'b1;
                    cmd.grant   = !stat.is_free;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_REM_MV;
                end
            end
            S_REM_MV:
            begin
                cmd.sel_used = stat.is_free;
                cmd.wr       = 1'b1;
                cmd.wr_prev  = 1'b1;
                cmd.wsel     = WD_RDATA;
                cmd.idx_op   = IDX_INC;
                state_next   = S_REM_CHK;
            end
            S_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[src/ffa_dp.sv]
`default_nettype none
module ffa_dp
    import ffa_pkg::*;
#(
    parameter int HEAP_BYTES = 65536,
    parameter int LIST_DEPTH = 256
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire dp_cmd_t   cmd,
    input  wire in_item_t  req_item,
    output dp_stat_t       stat,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output out_item_t      rsp_item
);

    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);
    localparam seg_t RESET_SEG = '{start: '0, size: SIZE_W'(HEAP_BYTES)};

    logic              is_free_reg;
    logic              avalid_reg;
    logic [SIZE_W-1:0] req_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [ADDR_W-1:0] cs_reg;
    logic [SIZE_W-1:0] cz_reg;
    logic [CNT_W-1:0]  free_cnt_reg;
    logic [CNT_W-1:0]  used_cnt_reg;
    logic              fresh_reg;
    logic              rd_zero_reg;
    status_t           status_reg;
    logic [ADDR_W-1:0] granted_reg;
    logic              rsp_valid_reg;
    out_item_t         rsp_item_reg;

    logic [CNT_W-1:0]  idx_m1;
    logic [CNT_W-1:0]  sel_cnt;
    logic [IDX_W-1:0]  raddr;
    logic [IDX_W-1:0]  waddr;
    seg_t              free_raw;
    seg_t              used_raw;
    seg_t              free_q;
    seg_t              rdata;
    seg_t              wdata;

    assign idx_m1  = idx_reg - CNT_W'(1);
    assign sel_cnt = cmd.sel_used ? used_cnt_reg : free_cnt_reg;
    assign raddr   = cmd.rd_prev ? idx_m1[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign waddr   = cmd.wr_prev ? idx_m1[IDX_W-1:0] : idx_reg[IDX_W-1:0];

    // Entry 0 of the free list holds the whole heap until first written
    assign free_q = (fresh_reg && rd_zero_reg) ? RESET_SEG : free_raw;
    assign rdata  = cmd.sel_used ? used_raw : free_q;

    always_comb
    begin
        case (cmd.wsel)
            WD_RDATA: wdata = rdata;
            WD_CAPT:  wdata = '{start: cs_reg, size: cz_reg};
            WD_GRANT: wdata = '{start: cs_reg, size: req_reg};
            WD_TAIL:  wdata = '{start: cs_reg + req_reg[ADDR_W-1:0], size: cz_reg - req_reg};
            default:  wdata = rdata;
        endcase
    end

    ffa_ram #(
        .WIDTH ($bits(seg_t)),
        .DEPTH (LIST_DEPTH)
    ) u_free_ram (
        .clk   (clk),
        .we    (cmd.wr && !cmd.sel_used),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd && !cmd.sel_used),
        .raddr (raddr),
        .rdata (free_raw)
    );

    ffa_ram #(
        .WIDTH ($bits(seg_t)),
        .DEPTH (LIST_DEPTH)
    ) u_used_ram (
        .clk   (clk),
        .we    (cmd.wr && cmd.sel_used),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd && cmd.sel_used),
        .raddr (raddr),
        .rdata (used_raw)
    );

    always_comb
    begin
        stat            = '0;
        stat.is_free    = is_free_reg;
        stat.addr_valid = avalid_reg;
        stat.req_zero   = (req_reg == '0);
        stat.idx_zero   = (idx_reg == '0);
        stat.idx_end    = (idx_reg >= sel_cnt);
        stat.hit        = is_free_reg ? (rdata.start == addr_reg) : (rdata.size >= req_reg);
        stat.key_less   = (cs_reg < rdata.start);
        stat.tail       = (cz_reg > req_reg);
        stat.free_full  = (free_cnt_reg >= DEPTH_CNT);
        stat.used_full  = (used_cnt_reg >= DEPTH_CNT);
        stat.out_busy   = rsp_valid_reg && !rsp_ready;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_cnt_reg  <= CNT_W'(1);
            used_cnt_reg  <= '0;
            fresh_reg     <= 1'b1;
            rd_zero_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_inc)
            begin
                if (cmd.sel_used)
                begin
                    used_cnt_reg <= used_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    free_cnt_reg <= free_cnt_reg + CNT_W'(1);
                end
            end
            if (cmd.cnt_dec)
            begin
                if (cmd.sel_used)
                begin
                    used_cnt_reg <= used_cnt_reg - CNT_W'(1);
                end
                else
                begin
                    free_cnt_reg <= free_cnt_reg - CNT_W'(1);
                end
            end
            if (cmd.wr && !cmd.sel_used && waddr == '0)
            begin
                fresh_reg <= 1'b0;
            end
            if (cmd.rd && !cmd.sel_used)
            begin
                rd_zero_reg <= (raddr == '0);
            end
            if (cmd.publish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            is_free_reg <= req_item.op;
            avalid_reg  <= req_item.addr_valid;
            req_reg     <= req_item.req_size;
            addr_reg    <= req_item.block_addr;
            status_reg  <= ST_OK;
            granted_reg <= '0;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status_val;
        end
        if (cmd.grant)
        begin
            granted_reg <= cs_reg;
        end
        if (cmd.capture)
        begin
            cs_reg  <= rdata.start;
            cz_reg  <= rdata.size;
            pos_reg <= idx_reg;
        end
        case (cmd.idx_op)
            IDX_HOLD: idx_reg <= cmd.load ? '0 : idx_reg;
            IDX_INC:  idx_reg <= idx_reg + CNT_W'(1);
            IDX_DEC:  idx_reg <= idx_m1;
            IDX_CNT:  idx_reg <= sel_cnt;
            IDX_POS:  idx_reg <= pos_reg;
            IDX_POS1: idx_reg <= pos_reg + CNT_W'(1);
            default:  idx_reg <= idx_reg;
        endcase
        if (cmd.publish)
        begin
            rsp_item_reg.granted_addr <= granted_reg;
            rsp_item_reg.status       <= status_reg;
            rsp_item_reg.free_entries <= CNT_OUT_W'(free_cnt_reg);
            rsp_item_reg.used_entries <= CNT_OUT_W'(used_cnt_reg);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule
`default_nettype wire
